// ===== design/bse_pkg.sv =====
// Shared types, constants and fixed-point helpers of the escape-time engine.
package bse_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int ITER_BITS  = 16;

  localparam int FIX_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * FIX_W;
  // Squares and cross terms after the fraction shift, with headroom for sums.
  localparam int WIDE_W    = PROD_W - FRAC_BITS + 2;
  // Coordinate times step product; the sum with the origin is formed at SAT_W.
  localparam int CPROD_W   = COORD_BITS + 1 + FIX_W;
  localparam int SAT_W     = (CPROD_W + 1 > WIDE_W) ? CPROD_W + 1 : WIDE_W;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER  = 3'd0,
    CFG_STEP_RE   = 3'd1,
    CFG_ORIGIN_RE = 3'd2,
    CFG_STEP_IM   = 3'd3,
    CFG_ORIGIN_IM = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        [ITER_BITS-1:0] max_iter;
    logic signed [FIX_W-1:0]     step_re;
    logic signed [FIX_W-1:0]     origin_re;
    logic signed [FIX_W-1:0]     step_im;
    logic signed [FIX_W-1:0]     origin_im;
  } cfg_regs_t;

  // One pixel with its point c, as it travels from front to back.
  typedef struct packed {
    logic        [COORD_BITS-1:0] x;
    logic        [COORD_BITS-1:0] y;
    logic signed [FIX_W-1:0]      c_re;
    logic signed [FIX_W-1:0]      c_im;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DONE
  } bse_state_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'((64'sd1 <<< (FIX_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'(64'sd1 <<< (FIX_W - 1));

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [SAT_W-1:0] v);
    logic signed [FIX_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[FIX_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[FIX_W-1:0];
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FIX_W-1:0] abs_sat(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] a;
    a = (v < 0) ? -v : v;
    return sat_fix(a);
  endfunction

endpackage

// ===== design/bse_if.sv =====
// Handshake interfaces for the pixel, result and configuration channels.
interface bse_pix_if
  import bse_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface bse_res_if
  import bse_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [ITER_BITS-1:0]  iterations;
  logic                  escaped;
  modport source (output valid, out_x, out_y, iterations, escaped, input ready);
  modport sink (input valid, out_x, out_y, iterations, escaped, output ready);
endinterface

interface bse_cfg_if
  import bse_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bse_front.sv =====
// Front end: takes pixels and maps each one to its point c.
module bse_front
  import bse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg_regs,
  bse_pix_if.sink   pix,
  output logic      q_valid,
  input  logic      q_ready,
  output item_t     q_item
);

  logic                        s1_valid;
  logic [COORD_BITS-1:0]       s1_x;
  logic [COORD_BITS-1:0]       s1_y;
  logic signed [CPROD_W-1:0]   s1_prod_re;
  logic signed [CPROD_W-1:0]   s1_prod_im;
  logic signed [COORD_BITS:0]  xs;
  logic signed [COORD_BITS:0]  ys;
  logic                        accept;

  assign xs        = {1'b0, pix.pixel_x};
  assign ys        = {1'b0, pix.pixel_y};
  assign pix.ready = !s1_valid || q_ready;
  assign accept    = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x       <= pix.pixel_x;
      s1_y       <= pix.pixel_y;
      s1_prod_re <= xs * cfg_regs.step_re;
      s1_prod_im <= ys * cfg_regs.step_im;
    end
  end

  assign q_valid     = s1_valid;
  assign q_item.x    = s1_x;
  assign q_item.y    = s1_y;
  assign q_item.c_re = sat_fix(SAT_W'(cfg_regs.origin_re) + SAT_W'(s1_prod_re));
  assign q_item.c_im = sat_fix(SAT_W'(cfg_regs.origin_im) + SAT_W'(s1_prod_im));

endmodule

// ===== design/bse_queue.sv =====
// Short queue of prepared pixels between the front end and the iteration engine.
module bse_queue
  import bse_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = count != (QPTR_W + 1)'(QDEPTH);
  assign rd_valid = count != '0;
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== design/bse_back.sv =====
// Iteration engine: runs the escape-time loop for one pixel and holds the result.
module bse_back
  import bse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg_regs,
  input  logic      q_valid,
  output logic      q_ready,
  input  item_t     q_item,
  bse_res_if.source res
);

  bse_state_t state;
  bse_state_t state_next;

  logic [COORD_BITS-1:0]   cur_x;
  logic [COORD_BITS-1:0]   cur_y;
  logic signed [FIX_W-1:0] z_real;
  logic signed [FIX_W-1:0] z_imag;
  logic signed [FIX_W-1:0] c_real;
  logic signed [FIX_W-1:0] c_imag;
  logic [ITER_BITS-1:0]    iter_count;
  logic                    esc_flag;

  logic signed [PROD_W-1:0] prod_rr;
  logic signed [PROD_W-1:0] prod_ii;
  logic signed [PROD_W-1:0] prod_ri;

  logic signed [PROD_W-1:0] sh_rr;
  logic signed [PROD_W-1:0] sh_ii;
  logic signed [PROD_W-1:0] sh_ri;
  logic signed [WIDE_W-1:0] sq_re;
  logic signed [WIDE_W-1:0] sq_im;
  logic signed [WIDE_W-1:0] cross_term;
  logic signed [WIDE_W-1:0] mag;
  logic signed [WIDE_W-1:0] new_im;
  logic signed [WIDE_W-1:0] new_re;
  logic                     esc;
  logic                     stop;
  logic                     res_load;

  localparam logic signed [WIDE_W-1:0] FOUR = WIDE_W'(64'sd4 <<< FRAC_BITS);

  // Floor division by 2^FRAC_BITS is an arithmetic right shift.
  assign sh_rr      = prod_rr >>> FRAC_BITS;
  assign sh_ii      = prod_ii >>> FRAC_BITS;
  assign sh_ri      = prod_ri >>> FRAC_BITS;
  assign sq_re      = sh_rr[WIDE_W-1:0];
  assign sq_im      = sh_ii[WIDE_W-1:0];
  assign cross_term = sh_ri[WIDE_W-1:0] <<< 1;
  assign mag        = sq_re + sq_im;
  assign esc        = mag >= FOUR;
  assign stop       = esc || (iter_count >= cfg_regs.max_iter);
  assign new_im     = cross_term - WIDE_W'(c_imag);
  assign new_re     = sq_re - sq_im - WIDE_W'(c_real);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stop ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_ready  = state == ST_IDLE;
    res_load = (state == ST_DONE) && (!res.valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur_x      <= q_item.x;
      cur_y      <= q_item.y;
      z_real     <= q_item.c_re;
      z_imag     <= q_item.c_im;
      c_real     <= q_item.c_re;
      c_imag     <= q_item.c_im;
      iter_count <= '0;
    end else if (state == ST_MUL) begin
      prod_rr <= z_real * z_real;
      prod_ii <= z_imag * z_imag;
      prod_ri <= z_real * z_imag;
    end else if (state == ST_CHECK) begin
      esc_flag <= esc;
      if (!stop) begin
        z_real     <= abs_sat(SAT_W'(new_re));
        z_imag     <= abs_sat(SAT_W'(new_im));
        iter_count <= iter_count + 1'b1;
      end
    end
  end

  // Result register: the engine can finish the next pixel while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.out_x      <= cur_x;
      res.out_y      <= cur_y;
      res.iterations <= iter_count;
      res.escaped    <= esc_flag;
    end
  end

`ifndef ASSERT_OFF
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (iter_count <= cfg_regs.max_iter))
    else $error("iteration count passed the limit");

  a_limit_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !esc_flag) |-> (iter_count == cfg_regs.max_iter))
    else $error("non-escaped pixel finished below the limit");

  a_check_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_CHECK))
    else $error("products were not evaluated after the multiply cycle");
`endif

endmodule

// ===== design/burning_ship_escape_time.sv =====
// Burning-ship escape-time engine: takes a pixel, returns its iteration count.
// Channels: pix carries pixel_x/pixel_y in, res carries out_x, out_y,
// iterations and escaped out, cfg writes the five registers (max_iter,
// step_re, origin_re, step_im, origin_im by index 0..4). Each channel is a
// valid/ready pair; a transfer happens on a clock edge with both high.
// Configuration is accepted every cycle and must be written only while idle.
// A pixel is held in the front-end register while c is formed, then waits
// in a four-entry queue. The iteration engine loads it in ST_IDLE, then runs
// magnitude tests, each a multiply state (ST_MUL) followed by a compare and
// update state (ST_CHECK), with n + 1 tests for a pixel that runs n
// iterations, and hands the result to the output register from ST_DONE. The
// engine takes no new pixel until it is back in ST_IDLE; that loop sets the
// throughput. A pixel passes the front-end register, the queue, the engine
// and the output register on its way from input transfer to result valid.
// A synchronous active-high rst empties the queue and the pipeline and puts
// the registers back to max_iter 64 with zero steps and origins.
// When res.ready is low the finished result holds in the output register, the
// engine completes one more pixel behind it, and the queue and front end keep
// taking pixels until they fill up.
module burning_ship_escape_time
  import bse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bse_pix_if.sink   pix,
  bse_res_if.source res,
  bse_cfg_if.sink   cfg
);

  cfg_regs_t cfg_regs;
  logic      f_valid;
  logic      f_ready;
  item_t     f_item;
  logic      b_valid;
  logic      b_ready;
  item_t     b_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.max_iter  <= ITER_BITS'(64);
      cfg_regs.step_re   <= '0;
      cfg_regs.origin_re <= '0;
      cfg_regs.step_im   <= '0;
      cfg_regs.origin_im <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MAX_ITER:  cfg_regs.max_iter  <= cfg.data[ITER_BITS-1:0];
        CFG_STEP_RE:   cfg_regs.step_re   <= cfg.data[FIX_W-1:0];
        CFG_ORIGIN_RE: cfg_regs.origin_re <= cfg.data[FIX_W-1:0];
        CFG_STEP_IM:   cfg_regs.step_im   <= cfg.data[FIX_W-1:0];
        CFG_ORIGIN_IM: cfg_regs.origin_im <= cfg.data[FIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .pix      (pix),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  bse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  bse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_item   (b_item),
    .res      (res)
  );

endmodule
